>>> design/bbr_pkg.sv
// bbr_pkg: shared constants, types and codes of the 3x3 box blur
// no dependencies; used by the channel interfaces and every module
`default_nettype none

package bbr_pkg;

   // frame geometry
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 12;
   localparam int OUT_POS_W  = 11;

   // pixel layout
   localparam int IN_PIX_W = 32;
   localparam int CH_W     = 8;
   localparam int NUM_CH   = 3;
   localparam int PIX_W    = CH_W * NUM_CH;
   localparam int WIN_N    = 3;
   localparam int SUM_W    = 12;

   // floor(s / 9) as (s * 7282) >> 16, exact for s below 4096
   localparam int DIV9_RECIP_W = 13;
   localparam logic [DIV9_RECIP_W-1:0] DIV9_RECIP = 13'd7282;
   localparam int DIV9_SHIFT   = 16;
   localparam int PROD_W       = SUM_W + DIV9_RECIP_W;

   // register defaults and limits
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd1024;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd768;
   localparam logic [SIZE_W-1:0] MIN_SIZE     = 12'd3;
   localparam logic [SIZE_W-1:0] WIDTH_LIMIT  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_LIMIT = SIZE_W'(MAX_HEIGHT);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // result buffer
   localparam int OUT_DEPTH = 8;
   localparam int OPTR_W    = $clog2(OUT_DEPTH);

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // one classified pixel, front to back
   typedef struct packed {
      pixel_type               pixel;
      logic [COL_W-1:0]        col;
      logic                    emit;
      logic [OUT_POS_W-1:0]    out_col;
      logic [OUT_POS_W-1:0]    out_row;
   } item_type;

   // one finished result
   typedef struct packed {
      pixel_type               color;
      logic [OUT_POS_W-1:0]    col;
      logic [OUT_POS_W-1:0]    row;
   } result_type;

   // queue status toward the front
   typedef struct packed {
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

>>> design/bbr_if.sv
// bbr_req_if / bbr_rsp_if: valid/ready channels of the box blur
// depends on bbr_pkg for field widths
`default_nettype none

interface bbr_req_if;
   import bbr_pkg::*;
   logic                valid;
   logic                ready;
   logic [IN_PIX_W-1:0] pixel_color;
   logic                frame_start;

   modport source (output valid, output pixel_color, output frame_start, input ready);
   modport sink (input valid, input pixel_color, input frame_start, output ready);
endinterface

interface bbr_rsp_if;
   import bbr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PIX_W-1:0]     out_color;
   logic [OUT_POS_W-1:0] out_col;
   logic [OUT_POS_W-1:0] out_row;

   modport source (output valid, output out_color, output out_col, output out_row,
                   input ready);
   modport sink (input valid, input out_color, input out_col, input out_row,
                 output ready);
endinterface

`default_nettype wire

>>> design/bbr_front.sv
// bbr_front: size registers, position counters and interior classification
// depends on bbr_pkg and bbr_req_if; feeds bbr_queue
`default_nettype none

module bbr_front (
   input  logic                           clock,
   input  logic                           reset,
   bbr_req_if.sink                        req_ch,
   input  logic                           csr_write_en,
   input  logic [bbr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bbr_pkg::SIZE_W-1:0]     csr_data,
   input  bbr_pkg::queue_status_type      q_status,
   output logic                           push,
   output bbr_pkg::item_type              push_item
);
   import bbr_pkg::*;

   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic [SIZE_W-1:0] w_eff, h_eff;
   logic [COL_W-1:0]  col_cur;
   logic [ROW_W-1:0]  row_cur;
   logic [SIZE_W-1:0] col_inc, row_inc;
   logic              transfer;
   logic              emit;

   // configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_in  = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            default:          width_in  = width_ff;
         endcase
      end
   end

   // effective frame size
   always_comb begin
      priority if (width_ff < MIN_SIZE) w_eff = MIN_SIZE;
      else if (width_ff > WIDTH_LIMIT)  w_eff = WIDTH_LIMIT;
      else                              w_eff = width_ff;
      priority if (height_ff < MIN_SIZE) h_eff = MIN_SIZE;
      else if (height_ff > HEIGHT_LIMIT) h_eff = HEIGHT_LIMIT;
      else                               h_eff = height_ff;
   end

   assign req_ch.ready = !q_status.full;
   assign transfer     = req_ch.valid && req_ch.ready;

   // position of this pixel and whether it closes an interior window
   always_comb begin
      col_cur = req_ch.frame_start ? '0 : col_ff;
      row_cur = req_ch.frame_start ? '0 : row_ff;
      emit = (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2))
           && (SIZE_W'(col_cur) < w_eff) && (SIZE_W'(row_cur) < h_eff);
   end

   // counter advance with wrap at the frame edges
   always_comb begin
      col_inc = SIZE_W'(col_cur) + SIZE_W'(1);
      row_inc = SIZE_W'(row_cur) + SIZE_W'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (transfer) begin
         if (col_inc >= w_eff) begin
            col_in = '0;
            row_in = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // classified item toward the queue
   always_comb begin
      push              = transfer;
      push_item.pixel   = req_ch.pixel_color[PIX_W-1:0];
      push_item.col     = col_cur;
      push_item.emit    = emit;
      push_item.out_col = OUT_POS_W'(col_cur - COL_W'(1));
      push_item.out_row = OUT_POS_W'(row_cur - ROW_W'(1));
   end

endmodule

`default_nettype wire

>>> design/bbr_queue.sv
// bbr_queue: short item queue between the front and the back
// depends on bbr_pkg
`default_nettype none

module bbr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bbr_pkg::item_type         push_item,
   output bbr_pkg::queue_status_type q_status,
   input  logic                      pop,
   output logic                      head_valid,
   output bbr_pkg::item_type         head_item
);
   import bbr_pkg::*;

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign q_status.full = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> design/bbr_back.sv
// bbr_back: line memory, 3x3 window, channel sums, divide by nine, result buffer
// depends on bbr_pkg and bbr_rsp_if; drains bbr_queue
`default_nettype none

module bbr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  bbr_pkg::item_type head_item,
   output logic              pop,
   bbr_rsp_if.source         rsp_ch
);
   import bbr_pkg::*;

   // line memory word: row two above in the upper half, row above in the lower
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_word_ff;

   logic               p1_valid_ff;
   item_type           p1_item_ff;
   logic               p1_byp_ff;
   logic [2*PIX_W-1:0] p1_byp_word_ff;
   logic [2*PIX_W-1:0] p1_word;
   logic [2*PIX_W-1:0] wr_word;
   pixel_type          above, above2;

   pixel_type          win_ff [WIN_N][WIN_N];

   logic               p2_emit_ff;
   logic [OUT_POS_W-1:0] p2_col_ff, p2_row_ff;
   logic [SUM_W-1:0]   sum [NUM_CH];

   logic               p3_emit_ff;
   logic [OUT_POS_W-1:0] p3_col_ff, p3_row_ff;
   logic [SUM_W-1:0]   sum_ff [NUM_CH];
   logic [PROD_W-1:0]  prod [NUM_CH];
   result_type         result;

   result_type         out_mem [OUT_DEPTH];
   logic [OPTR_W-1:0]  out_wr_ff, out_rd_ff;
   logic [OPTR_W:0]    out_count_ff, out_count_in;
   logic [OPTR_W:0]    pending;
   logic               out_push, out_pop;

   // pop only with room in the result buffer for everything in flight
   always_comb begin
      pending = out_count_ff
              + (OPTR_W+1)'(p1_valid_ff && p1_item_ff.emit)
              + (OPTR_W+1)'(p2_emit_ff)
              + (OPTR_W+1)'(p3_emit_ff);
      pop = head_valid && (pending < (OPTR_W+1)'(OUT_DEPTH));
   end

   // line word seen by the item in stage one, bypassing a same-column write
   always_comb begin
      p1_word = p1_byp_ff ? p1_byp_word_ff : rd_word_ff;
      above2  = p1_word[2*PIX_W-1:PIX_W];
      above   = p1_word[PIX_W-1:0];
      wr_word = {above, p1_item_ff.pixel};
   end

   // line memory read at pop, written back from stage one in the next cycle
   always_ff @(posedge clock) begin
      if (pop) begin
         rd_word_ff <= line_mem[head_item.col];
      end
      if (p1_valid_ff) begin
         line_mem[p1_item_ff.col] <= wr_word;
      end
   end

   // stage one registers
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p1_item_ff     <= head_item;
         p1_byp_ff      <= p1_valid_ff && (p1_item_ff.col == head_item.col);
         p1_byp_word_ff <= wr_word;
      end
   end

   // window shift: oldest column on the left, new column on the right
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < WIN_N; c++) begin
            for (int r = 0; r < WIN_N; r++) begin
               win_ff[c][r] <= '0;
            end
         end
      end else if (p1_valid_ff) begin
         for (int c = 0; c < WIN_N - 1; c++) begin
            for (int r = 0; r < WIN_N; r++) begin
               win_ff[c][r] <= win_ff[c+1][r];
            end
         end
         win_ff[WIN_N-1][0] <= above2;
         win_ff[WIN_N-1][1] <= above;
         win_ff[WIN_N-1][2] <= p1_item_ff.pixel;
      end
   end

   // stage two: per-channel sums over the window
   always_ff @(posedge clock) begin
      if (reset) begin
         p2_emit_ff <= 1'b0;
      end else begin
         p2_emit_ff <= p1_valid_ff && p1_item_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      p2_col_ff <= p1_item_ff.out_col;
      p2_row_ff <= p1_item_ff.out_row;
   end

   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         sum[k] = '0;
         for (int c = 0; c < WIN_N; c++) begin
            for (int r = 0; r < WIN_N; r++) begin
               sum[k] = sum[k] + SUM_W'(win_ff[c][r][k*CH_W +: CH_W]);
            end
         end
      end
   end

   // stage three: sums registered
   always_ff @(posedge clock) begin
      if (reset) begin
         p3_emit_ff <= 1'b0;
      end else begin
         p3_emit_ff <= p2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3_col_ff <= p2_col_ff;
      p3_row_ff <= p2_row_ff;
      for (int k = 0; k < NUM_CH; k++) begin
         sum_ff[k] <= sum[k];
      end
   end

   // divide by nine through the reciprocal
   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         prod[k] = PROD_W'(sum_ff[k]) * PROD_W'(DIV9_RECIP);
         result.color[k*CH_W +: CH_W] = prod[k][DIV9_SHIFT +: CH_W];
      end
      result.col = p3_col_ff;
      result.row = p3_row_ff;
   end

   // result buffer
   assign out_push = p3_emit_ff;
   assign out_pop  = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      out_count_in = out_count_ff + (OPTR_W+1)'(out_push) - (OPTR_W+1)'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         out_count_ff <= out_count_in;
         if (out_push) begin
            out_wr_ff <= out_wr_ff + OPTR_W'(1);
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + OPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem[out_wr_ff] <= result;
      end
   end

   assign rsp_ch.valid     = (out_count_ff != '0);
   assign rsp_ch.out_color = out_mem[out_rd_ff].color;
   assign rsp_ch.out_col   = out_mem[out_rd_ff].col;
   assign rsp_ch.out_row   = out_mem[out_rd_ff].row;

endmodule

`default_nettype wire

>>> design/box_blur_3x3_rgb_top.sv
// box_blur_3x3_rgb_top: 3x3 box blur over a raster pixel stream
// depends on bbr_pkg, bbr_if, bbr_front, bbr_queue, bbr_back
//
//   channel   direction  handshake          payload
//   req_ch    in         valid/ready        pixel_color, frame_start
//   rsp_ch    out        valid/ready        out_color, out_col, out_row
//   csr_*     in         csr_write_en only  csr_index, csr_data (12 bits)
//
// one pixel per cycle sustained while neither the queue nor the result buffer stalls;
// a result reaches the result buffer from its pixel transfer through the queue, the
// line memory read, the window sum and the reciprocal multiply stages
// each pixel does one read and one write of the single line memory word for its column
// synchronous reset clears counters, queue, pipeline valids and window; line memory
// needs no clearing pass
// the front stalls only when the four-entry queue is full; the back stalls when the
// eight-entry result buffer cannot take what is in flight
`default_nettype none

module box_blur_3x3_rgb_top (
   input  logic                            clock,
   input  logic                            reset,
   bbr_req_if.sink                         req_ch,
   bbr_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_en,
   input  logic [bbr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bbr_pkg::SIZE_W-1:0]      csr_data
);
   import bbr_pkg::*;

   queue_status_type q_status;
   logic             push;
   item_type         push_item;
   logic             pop;
   logic             head_valid;
   item_type         head_item;

   // classify
   bbr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .q_status     (q_status),
      .push         (push),
      .push_item    (push_item)
   );

   // decouple
   bbr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .q_status   (q_status),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // filter
   bbr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire
